// ----- hw/rtl/gms_pkg.sv -----
// Types, codes and reset values shared by the gripper mode sequencer.
`timescale 1ns / 1ps

package gms_pkg;

   localparam logic [1:0] KIND_MODE   = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_CAMERA = 2'd2;

   localparam logic [7:0] MODE_INIT        = 8'd6;
   localparam logic [7:0] MODE_READY       = 8'd7;
   localparam logic [7:0] MODE_PICK_UP     = 8'd8;
   localparam logic [7:0] MODE_PICK_MIDDLE = 8'd9;
   localparam logic [7:0] MODE_PICK_DOWN   = 8'd10;
   localparam logic [7:0] MODE_HOLD        = 8'd11;
   localparam logic [7:0] MODE_SHOOT       = 8'd13;

   localparam logic [1:0] HEIGHT_UP     = 2'd0;
   localparam logic [1:0] HEIGHT_MIDDLE = 2'd1;
   localparam logic [1:0] HEIGHT_DOWN   = 2'd2;

   localparam logic [2:0] PHASE_RAMP_UP   = 3'd0;
   localparam logic [2:0] PHASE_RELEASE   = 3'd1;
   localparam logic [2:0] PHASE_WAIT      = 3'd2;
   localparam logic [2:0] PHASE_RAMP_DOWN = 3'd3;
   localparam logic [2:0] PHASE_DONE      = 3'd4;

   localparam logic [2:0] CSR_RAMP_STEP    = 3'd0;
   localparam logic [2:0] CSR_PEAK_ANGLE   = 3'd1;
   localparam logic [2:0] CSR_RELEASE_ANGLE = 3'd2;
   localparam logic [2:0] CSR_WAIT_TICKS   = 3'd3;
   localparam logic [2:0] CSR_UP_READY     = 3'd4;
   localparam logic [2:0] CSR_LOW_READY    = 3'd5;

   typedef struct packed {
      logic [3:0]  ramp_step;
      logic [8:0]  hold_peak_angle;
      logic [8:0]  hold_release_angle;
      logic [15:0] hold_wait_ticks;
      logic [8:0]  up_ready_angle;
      logic [8:0]  low_ready_angle;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] mode_code;
      logic [8:0] camera_angle;
   } req_type;

   typedef struct packed {
      logic [7:0]  active_mode;
      logic [8:0]  grip_angle;
      logic [8:0]  camera_angle;
      logic        cylinder_bit;
      logic        hand_bit;
      logic [2:0]  phase_reg;
      logic [15:0] wait_counter;
      logic [1:0]  pick_height;
   } state_type;

   typedef struct packed {
      logic [8:0] grip_angle;
      logic [8:0] camera_servo;
      logic       cylinder_extend;
      logic       hand_close;
      logic [2:0] hold_phase;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      ramp_step:          4'd2,
      hold_peak_angle:    9'd217,
      hold_release_angle: 9'd200,
      hold_wait_ticks:    16'd200,
      up_ready_angle:     9'd45,
      low_ready_angle:    9'd90
   };

   localparam state_type STATE_RESET = '{
      active_mode:  8'd0,
      grip_angle:   9'd0,
      camera_angle: 9'd0,
      cylinder_bit: 1'b0,
      hand_bit:     1'b0,
      phase_reg:    PHASE_RAMP_UP,
      wait_counter: 16'd0,
      pick_height:  HEIGHT_DOWN
   };

endpackage

// ----- hw/rtl/gms_if.sv -----
// Valid/ready channel interfaces for request, response and register write words.
`timescale 1ns / 1ps

interface gms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] mode_code;
   logic [8:0] camera_angle;

   modport source (output valid, kind, mode_code, camera_angle, input ready);
   modport sink (input valid, kind, mode_code, camera_angle, output ready);
endinterface

interface gms_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] grip_angle;
   logic [8:0] camera_servo;
   logic       cylinder_extend;
   logic       hand_close;
   logic [2:0] hold_phase;

   modport source (output valid, grip_angle, camera_servo, cylinder_extend, hand_close,
                   hold_phase, input ready);
   modport sink (input valid, grip_angle, camera_servo, cylinder_extend, hand_close,
                 hold_phase, output ready);
endinterface

interface gms_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gms_csr.sv -----
// Configuration register file of the gripper mode sequencer.
`timescale 1ns / 1ps

module gms_csr (
   input  logic             clock,
   input  logic             reset,
   gms_csr_if.sink          csr_if,
   output gms_pkg::cfg_type cfg
);
   import gms_pkg::*;

   cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_RAMP_STEP:     cfg_ff.ramp_step          <= csr_if.data[3:0];
            CSR_PEAK_ANGLE:    cfg_ff.hold_peak_angle    <= csr_if.data[8:0];
            CSR_RELEASE_ANGLE: cfg_ff.hold_release_angle <= csr_if.data[8:0];
            CSR_WAIT_TICKS:    cfg_ff.hold_wait_ticks    <= csr_if.data;
            CSR_UP_READY:      cfg_ff.up_ready_angle     <= csr_if.data[8:0];
            CSR_LOW_READY:     cfg_ff.low_ready_angle    <= csr_if.data[8:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/gms_step.sv -----
// Next-state logic for one request word: mode changes, hold sequence, camera writes.
`timescale 1ns / 1ps

module gms_step (
   input  gms_pkg::cfg_type   cfg,
   input  gms_pkg::state_type state,
   input  gms_pkg::req_type   req_word,
   output gms_pkg::state_type state_next
);
   import gms_pkg::*;

   function automatic logic [8:0] ready_angle(input logic [1:0] height, input cfg_type c);
      return (height == HEIGHT_UP) ? c.up_ready_angle : c.low_ready_angle;
   endfunction

   function automatic state_type hold_step(input state_type s, input cfg_type c);
      state_type   r;
      logic [9:0]  up_sum;
      logic [9:0]  rel_sum;
      logic [15:0] wc;
      r       = s;
      up_sum  = {1'b0, s.grip_angle} + {6'd0, c.ramp_step};
      rel_sum = {1'b0, c.hold_release_angle} + {6'd0, c.ramp_step};
      wc      = s.wait_counter + 16'd1;
      case (s.phase_reg)
         PHASE_RAMP_UP: begin
            if (s.grip_angle >= c.hold_peak_angle) begin
               r.phase_reg = PHASE_RELEASE;
            end else if (up_sum <= {1'b0, c.hold_peak_angle}) begin
               r.grip_angle = up_sum[8:0];
            end else begin
               r.grip_angle = c.hold_peak_angle;
            end
         end
         PHASE_RELEASE: begin
            r.cylinder_bit = 1'b0;
            r.wait_counter = 16'd0;
            r.phase_reg    = PHASE_WAIT;
         end
         PHASE_WAIT: begin
            r.wait_counter = wc;
            if (wc >= c.hold_wait_ticks) begin
               r.phase_reg = PHASE_RAMP_DOWN;
            end
         end
         PHASE_RAMP_DOWN: begin
            if (s.grip_angle <= c.hold_release_angle) begin
               r.phase_reg = PHASE_DONE;
            end else if ({1'b0, s.grip_angle} >= rel_sum) begin
               r.grip_angle = s.grip_angle - {5'd0, c.ramp_step};
            end else begin
               r.grip_angle = c.hold_release_angle;
            end
         end
         default: begin
            r.grip_angle   = c.hold_release_angle;
            r.cylinder_bit = 1'b0;
         end
      endcase
      return r;
   endfunction

   logic      mode_entry;
   state_type hold_in;
   state_type hold_out;

   always_comb begin
      mode_entry = (req_word.kind == KIND_MODE) && (req_word.mode_code != state.active_mode);
      hold_in    = state;
      if (mode_entry) begin
         hold_in.phase_reg = PHASE_RAMP_UP;
      end
      hold_out   = hold_step(hold_in, cfg);
      state_next = state;
      case (req_word.kind)
         KIND_MODE: begin
            if (mode_entry) begin
               state_next.active_mode = req_word.mode_code;
               state_next.phase_reg   = PHASE_RAMP_UP;
               if (req_word.mode_code == MODE_HOLD) begin
                  state_next             = hold_out;
                  state_next.active_mode = req_word.mode_code;
               end else begin
                  state_next.grip_angle   = 9'd0;
                  state_next.cylinder_bit = 1'b0;
                  state_next.hand_bit     = 1'b0;
                  case (req_word.mode_code)
                     MODE_READY: begin
                        state_next.grip_angle   = ready_angle(state.pick_height, cfg);
                        state_next.cylinder_bit = 1'b1;
                     end
                     MODE_PICK_UP: begin
                        state_next.pick_height  = HEIGHT_UP;
                        state_next.grip_angle   = ready_angle(HEIGHT_UP, cfg);
                        state_next.cylinder_bit = 1'b1;
                        state_next.hand_bit     = 1'b1;
                     end
                     MODE_PICK_MIDDLE: begin
                        state_next.pick_height  = HEIGHT_MIDDLE;
                        state_next.grip_angle   = ready_angle(HEIGHT_MIDDLE, cfg);
                        state_next.cylinder_bit = 1'b1;
                        state_next.hand_bit     = 1'b1;
                     end
                     MODE_PICK_DOWN: begin
                        state_next.pick_height  = HEIGHT_DOWN;
                        state_next.grip_angle   = ready_angle(HEIGHT_DOWN, cfg);
                        state_next.cylinder_bit = 1'b1;
                        state_next.hand_bit     = 1'b1;
                     end
                     MODE_SHOOT: begin
                        state_next.cylinder_bit = 1'b1;
                        state_next.hand_bit     = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         KIND_TICK: begin
            if (state.active_mode == MODE_HOLD) begin
               state_next = hold_out;
            end
         end
         KIND_CAMERA: begin
            state_next.camera_angle = req_word.camera_angle;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/gripper_mode_sequencer_top.sv -----
// Gripper mode sequencer top level: request register, state, response register.
//
// Channels: req_if carries request words (kind, mode_code, camera_angle);
// rsp_if returns one snapshot word per request (grip_angle, camera_servo,
// cylinder_extend, hand_close, hold_phase); csr_if writes the six
// configuration registers by index and is always ready.
// Pipeline: a request word accepted by req_if is registered in the request
// register, its state update and response are computed from that register,
// and the response register takes them once it is empty or draining.
// Throughput: one request word per cycle while rsp_if.ready is high; the
// combinational state update between the two registers sets this rate.
// Stall: while rsp_if.ready is low the response register holds its word;
// one more request word is taken into the request register, then req_if
// ready drops until the response drains.
// Reset: synchronous, active high; clears both registers' valid flags,
// the mode state (pick height returns to down) and loads register defaults.
// The user must write configuration only with no request words in flight; not enforced.
`timescale 1ns / 1ps

module gripper_mode_sequencer_top (
   input  logic     clock,
   input  logic     reset,
   gms_req_if.sink   req_if,
   gms_rsp_if.source rsp_if,
   gms_csr_if.sink   csr_if
);
   import gms_pkg::*;

   cfg_type    cfg;
   req_type    req_ff;
   logic       req_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       advance;

   gms_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   gms_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .req_word   (req_ff),
      .state_next (state_in)
   );

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;

   assign rsp_in.grip_angle      = state_in.grip_angle;
   assign rsp_in.camera_servo    = state_in.camera_angle;
   assign rsp_in.cylinder_extend = state_in.cylinder_bit;
   assign rsp_in.hand_close      = state_in.hand_bit;
   assign rsp_in.hold_phase      = state_in.phase_reg;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_if.ready) begin
            req_valid_ff <= req_if.valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold payload until the next transfer
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         req_ff.kind         <= req_if.kind;
         req_ff.mode_code    <= req_if.mode_code;
         req_ff.camera_angle <= req_if.camera_angle;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.grip_angle      = rsp_ff.grip_angle;
   assign rsp_if.camera_servo    = rsp_ff.camera_servo;
   assign rsp_if.cylinder_extend = rsp_ff.cylinder_extend;
   assign rsp_if.hand_close      = rsp_ff.hand_close;
   assign rsp_if.hold_phase      = rsp_ff.hold_phase;

`ifndef ASSERT_OFF
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase_reg <= PHASE_DONE)
      else $error("hold phase out of range");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response word lost after advance");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_if.ready)
      else $error("request stalled with empty response register");

   a_tick_outside_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.kind == KIND_TICK && state_ff.active_mode != MODE_HOLD)
      |=> $stable(state_ff))
      else $error("tick outside hold changed state");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an accepted word");
`endif

endmodule
